// ----- sv/dhp_pkg.sv -----
// ----------------------------------------------------------------------------
// dhp_pkg: shared types and constants of the go-to-goal PID block
// Holds register indexes, command/status structs and widths.
// ----------------------------------------------------------------------------
package dhp_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_H = 3'd5;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SQRT_STEPS = 26;

    // Datapath operations, one per controller step
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_SQRT  = 3'd2;
    localparam logic [2:0] OP_ERR   = 3'd3;
    localparam logic [2:0] OP_MUL_P = 3'd4;
    localparam logic [2:0] OP_MUL_I = 3'd5;
    localparam logic [2:0] OP_MUL_D = 3'd6;
    localparam logic [2:0] OP_FIN   = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic       sel_head;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
    } t_status;

endpackage

// ----- sv/distance_heading_pid.sv -----
// ----------------------------------------------------------------------------
// distance_heading_pid: go-to-goal controller with two shared-gain PID loops
// Each item runs a load step, 26 root steps and 5 steps per loop (error, P, I and D
// products, finish), then waits for output ready; one item in flight.
// The bit-serial square root and the shared multiplier set this step sequence.
// Reset (synchronous, active low) clears integrals, previous errors, gains
// and targets to their reset values.
// ----------------------------------------------------------------------------
module distance_heading_pid
    import dhp_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [23:0]    i_pos_x,
    input  logic signed [23:0]    i_pos_y,
    input  logic signed [23:0]    i_heading,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_linear_drive,
    output logic signed [31:0]    o_angular_drive,
    output logic                  o_at_target
);

    logic [15:0]        r_gp, r_gi, r_gd;
    logic signed [23:0] r_tx, r_ty, r_th;
    t_cmd               w_cmd;
    t_status            w_status;

    assign o_cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp <= 16'd256; r_gi <= '0; r_gd <= '0;
            r_tx <= 24'sd122880; r_ty <= 24'sd122880; r_th <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GAIN_P:   r_gp <= i_cfg_data[15:0];
                REG_GAIN_I:   r_gi <= i_cfg_data[15:0];
                REG_GAIN_D:   r_gd <= i_cfg_data[15:0];
                REG_TARGET_X: r_tx <= i_cfg_data[23:0];
                REG_TARGET_Y: r_ty <= i_cfg_data[23:0];
                REG_TARGET_H: r_th <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    dhp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .o_cmd(w_cmd), .i_status(w_status)
    );

    dhp_datapath #(.TICKS(TICKS_PER_SECOND)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_gp(r_gp), .i_gi(r_gi), .i_gd(r_gd),
        .i_tx(r_tx), .i_ty(r_ty), .i_th(r_th),
        .i_pos_x, .i_pos_y, .i_heading,
        .o_lin(o_linear_drive), .o_ang(o_angular_drive), .o_at(o_at_target)
    );

endmodule

// ----- sv/dhp_datapath.sv -----
// ----------------------------------------------------------------------------
// dhp_datapath: offsets, bit-serial square root, error terms and MAC
// One shared 41x17 multiplier computes the three PID products per loop.
// ----------------------------------------------------------------------------
module dhp_datapath
    import dhp_pkg::*;
#(
    parameter int unsigned TICKS = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [15:0]        i_gp,
    input  logic [15:0]        i_gi,
    input  logic [15:0]        i_gd,
    input  logic signed [23:0] i_tx,
    input  logic signed [23:0] i_ty,
    input  logic signed [23:0] i_th,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_heading,
    output logic signed [31:0] o_lin,
    output logic signed [31:0] o_ang,
    output logic               o_at
);

    localparam logic signed [63:0] S32MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32MIN = -64'sd2147483648;

    // reciprocal of TICKS, exact for magnitudes below 2^26
    localparam int unsigned QUO_SHIFT = 36;
    localparam logic [63:0] QUO_RECIP =
        ((64'd1 << QUO_SHIFT) + 64'(TICKS) - 64'd1) / 64'(TICKS);

    logic [51:0]        r_rem;
    logic [25:0]        r_root;
    logic [4:0]         r_cnt;
    logic signed [24:0] r_eh;
    logic signed [31:0] r_dint, r_hint, r_dprev, r_hprev;
    logic signed [31:0] r_e;       // current loop error
    logic signed [31:0] r_q;       // current loop error / TICKS
    logic signed [40:0] r_dd;      // error difference times TICKS
    logic signed [63:0] r_acc;
    logic signed [31:0] r_lin, r_ang;
    logic               r_at;

    logic signed [24:0] w_dx, w_dy;
    logic signed [49:0] w_dx2, w_dy2;
    logic signed [26:0] w_qsrc;
    logic [26:0]        w_qmag;
    logic [63:0]        w_qprod;
    logic [26:0]        w_quo;
    logic signed [31:0] w_qval;
    logic signed [63:0] w_isum, w_prod, w_sh;
    logic signed [40:0] w_mopa;
    logic signed [16:0] w_mopb;
    logic signed [31:0] w_i_new;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > S32MAX) return 32'sh7fffffff;
        if (v < S32MIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    assign w_dx  = 25'(i_tx) - 25'(i_pos_x);
    assign w_dy  = 25'(i_ty) - 25'(i_pos_y);
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;

    // one root bit per step: trial = rem_hi - (4*root + 1)
    logic [27:0] w_top, w_sub;
    logic [27:0] r_part;
    assign w_top = {r_part[25:0], r_rem[51:50]};
    assign w_sub = {r_root, 2'b01};

    // integral increment: error / TICKS, truncated toward zero
    assign w_qsrc  = i_cmd.sel_head ? 27'(r_eh) : $signed({1'b0, r_root});
    assign w_qmag  = w_qsrc[26] ? 27'(-w_qsrc) : 27'(w_qsrc);
    assign w_qprod = 64'(w_qmag) * QUO_RECIP;
    assign w_quo   = 27'(w_qprod >> QUO_SHIFT);
    assign w_qval  = w_qsrc[26] ? -$signed(32'(w_quo)) : $signed(32'(w_quo));

    assign w_isum  = 64'(i_cmd.sel_head ? r_hint : r_dint) + 64'(r_q);
    assign w_i_new = sat32(w_isum);

    always_comb begin
        w_mopa = 41'(r_e);
        w_mopb = $signed({1'b0, i_gp});
        case (i_cmd.op)
            OP_MUL_I: begin
                w_mopa = 41'(i_cmd.sel_head ? r_hint : r_dint);
                w_mopb = $signed({1'b0, i_gi});
            end
            OP_MUL_D: begin
                w_mopa = r_dd;
                w_mopb = $signed({1'b0, i_gd});
            end
            default: ;
        endcase
    end
    assign w_prod = 64'(w_mopa * w_mopb);
    assign w_sh   = r_acc >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dint <= '0; r_hint <= '0; r_dprev <= '0; r_hprev <= '0;
            r_cnt  <= '0; r_at <= 1'b0; r_lin <= '0; r_ang <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_rem  <= 52'(w_dx2) + 52'(w_dy2);
                    r_part <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                    r_eh   <= 25'(i_th) - 25'(i_heading);
                end
                OP_SQRT: begin
                    r_rem <= {r_rem[49:0], 2'b00};
                    if (w_top >= w_sub) begin
                        r_part <= w_top - w_sub;
                        r_root <= {r_root[24:0], 1'b1};
                    end else begin
                        r_part <= w_top;
                        r_root <= {r_root[24:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                OP_ERR: begin
                    r_at <= (r_root == '0);
                    r_q  <= w_qval;
                    if (i_cmd.sel_head) begin
                        r_e  <= 32'(r_eh);
                        r_dd <= (41'(r_eh) - 41'(r_hprev)) * $signed(41'(TICKS));
                    end else begin
                        r_e  <= 32'(r_root);
                        r_dd <= (41'($signed({1'b0, r_root})) - 41'(r_dprev))
                                * $signed(41'(TICKS));
                    end
                end
                OP_MUL_P: begin
                    r_acc <= w_prod;
                    if (!r_at) begin
                        if (i_cmd.sel_head) r_hint <= w_i_new;
                        else                r_dint <= w_i_new;
                    end
                end
                OP_MUL_I, OP_MUL_D: r_acc <= r_acc + w_prod;
                OP_FIN: begin
                    if (i_cmd.sel_head) begin
                        r_ang   <= r_at ? '0 : sat32(w_sh);
                        r_hprev <= r_e;
                    end else begin
                        r_lin   <= r_at ? '0 : sat32(w_sh);
                        r_dprev <= r_e;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status.sqrt_done = (r_cnt == 5'(SQRT_STEPS - 1));
    assign o_lin = r_lin;
    assign o_ang = r_ang;
    assign o_at  = r_at;

endmodule

// ----- sv/dhp_ctrl.sv -----
// ----------------------------------------------------------------------------
// dhp_ctrl: sequencer of the go-to-goal PID block
// Steps load, root iterations, then the two loops, then presents the item.
// ----------------------------------------------------------------------------
module dhp_ctrl
    import dhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQRT = 4'd1;
    localparam logic [3:0] S_ERR  = 4'd2;
    localparam logic [3:0] S_MP   = 4'd3;
    localparam logic [3:0] S_MI   = 4'd4;
    localparam logic [3:0] S_MD   = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0] r_state, n_state;
    logic       r_head, n_head;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // sequence the steps
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        o_cmd.op = OP_NONE;
        o_cmd.sel_head = r_head;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.op = OP_LOAD;
                n_state = S_SQRT;
                n_head = 1'b0;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_status.sqrt_done) n_state = S_ERR;
            end
            S_ERR: begin o_cmd.op = OP_ERR;   n_state = S_MP; end
            S_MP:  begin o_cmd.op = OP_MUL_P; n_state = S_MI; end
            S_MI:  begin o_cmd.op = OP_MUL_I; n_state = S_MD; end
            S_MD:  begin o_cmd.op = OP_MUL_D; n_state = S_FIN; end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                if (r_head) n_state = S_OUT;
                else begin n_head = 1'b1; n_state = S_ERR; end
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
        end
    end

endmodule

// ----- sv/dhp_checker.sv -----
// ----------------------------------------------------------------------------
// dhp_checker: port-level checks of the go-to-goal PID block
// Watches handshakes and the result fields over time.
// ----------------------------------------------------------------------------
module dhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_linear_drive,
    input logic [31:0] o_angular_drive,
    input logic        o_at_target
);

    // at target means both drives are zero
    a_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_at_target |-> o_linear_drive == '0 && o_angular_drive == '0)
        else $error("drives nonzero at target");

    // never accept input while a result is pending
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready with result pending");

    // accepted input does not yield a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_out_valid)
        else $error("result too early");

    // held result stays stable
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_linear_drive) && $stable(o_angular_drive))
        else $error("result changed while stalled");

endmodule

bind distance_heading_pid dhp_checker u_chk (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
    .o_linear_drive, .o_angular_drive, .o_at_target
);
